// ----- hw/rtl/euler_xyz_vertex_rotation_unit_assert.svh -----
// Assertion macros for the Euler XYZ vertex rotation unit.
// No dependencies; included by erot_stage, which checks its own logic.
`ifndef EULER_XYZ_VERTEX_ROTATION_UNIT_ASSERT_SVH
`define EULER_XYZ_VERTEX_ROTATION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define EROT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define EROT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EROT_ASSERT(lbl, clk, rstn, prop, msg)
`define EROT_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/erot_pkg.sv -----
// Shared types and constants for the Euler XYZ vertex rotation unit.
// No dependencies.
package erot_pkg;

  localparam int unsigned COEF_W    = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_COS_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIN_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_COS_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIN_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_COS_Z = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIN_Z = 3'd5;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 16'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 16'sd0;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_x;
    logic signed [COEF_W-1:0] sin_x;
    logic signed [COEF_W-1:0] cos_y;
    logic signed [COEF_W-1:0] sin_y;
    logic signed [COEF_W-1:0] cos_z;
    logic signed [COEF_W-1:0] sin_z;
  } erot_coef_t;

endpackage

// ----- hw/rtl/erot_regs.sv -----
// APB register file holding the sine and cosine coefficients.
// Depends on erot_pkg.
module erot_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [erot_pkg::ADDR_W-1:0]       paddr,
  input  logic [erot_pkg::DATA_W-1:0]       pwdata,
  output logic [erot_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output erot_pkg::erot_coef_t              coef_o
);

  erot_pkg::erot_coef_t               coef_q, coef_d;
  logic [erot_pkg::IDX_W-1:0]         idx;
  logic signed [erot_pkg::COEF_W-1:0] wval;
  logic signed [erot_pkg::COEF_W-1:0] rval;
  logic                               wr_en;

  assign idx    = paddr[erot_pkg::ADDR_W-1:2];
  assign wval   = pwdata[erot_pkg::COEF_W-1:0];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign coef_o = coef_q;

  always_comb begin
    coef_d = coef_q;
    if (wr_en) begin
      unique case (idx)
        erot_pkg::REG_COS_X: coef_d.cos_x = wval;
        erot_pkg::REG_SIN_X: coef_d.sin_x = wval;
        erot_pkg::REG_COS_Y: coef_d.cos_y = wval;
        erot_pkg::REG_SIN_Y: coef_d.sin_y = wval;
        erot_pkg::REG_COS_Z: coef_d.cos_z = wval;
        erot_pkg::REG_SIN_Z: coef_d.sin_z = wval;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      erot_pkg::REG_COS_X: rval = coef_q.cos_x;
      erot_pkg::REG_SIN_X: rval = coef_q.sin_x;
      erot_pkg::REG_COS_Y: rval = coef_q.cos_y;
      erot_pkg::REG_SIN_Y: rval = coef_q.sin_y;
      erot_pkg::REG_COS_Z: rval = coef_q.cos_z;
      erot_pkg::REG_SIN_Z: rval = coef_q.sin_z;
      default: rval = erot_pkg::COEF_ZERO;
    endcase
  end

  assign prdata = {{(erot_pkg::DATA_W-erot_pkg::COEF_W){rval[erot_pkg::COEF_W-1]}}, rval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.cos_x <= erot_pkg::COEF_ONE;
      coef_q.sin_x <= erot_pkg::COEF_ZERO;
      coef_q.cos_y <= erot_pkg::COEF_ONE;
      coef_q.sin_y <= erot_pkg::COEF_ZERO;
      coef_q.cos_z <= erot_pkg::COEF_ONE;
      coef_q.sin_z <= erot_pkg::COEF_ZERO;
    end else begin
      coef_q <= coef_d;
    end
  end

endmodule

// ----- hw/rtl/erot_stage.sv -----
// One axis rotation: a product stage and a sum/saturate stage with valid/ready.
// Depends on erot_pkg and euler_xyz_vertex_rotation_unit_assert.svh.
`include "euler_xyz_vertex_rotation_unit_assert.svh"
module erot_stage #(
  parameter int unsigned CW    = 20,
  parameter bit          NEG_A = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [CW-1:0]              a_i,
  input  logic signed [CW-1:0]              b_i,
  input  logic signed [CW-1:0]              c_i,
  input  logic signed [erot_pkg::COEF_W-1:0] cos_i,
  input  logic signed [erot_pkg::COEF_W-1:0] sin_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [CW-1:0]              a_o,
  output logic signed [CW-1:0]              b_o,
  output logic signed [CW-1:0]              c_o
);

  localparam int unsigned PW = CW + 1 + erot_pkg::COEF_W;
  localparam int unsigned TW = PW - erot_pkg::FRAC_BITS;
  localparam int unsigned SW = TW + 1;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [CW:0]   a_ext, b_ext, a_sin;
  logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;
  logic signed [SW-1:0] sum0, sum1;
  logic signed [CW-1:0] sat0, sat1;
  logic                 rdy1, rdy2;

  logic                 v1_q, v1_d, v2_q, v2_d;
  logic signed [TW-1:0] ac_q, bs_q, as_q, bc_q;
  logic signed [CW-1:0] c1_q;
  logic signed [CW-1:0] a2_q, b2_q, c2_q;

  assign a_ext = {a_i[CW-1], a_i};
  assign b_ext = {b_i[CW-1], b_i};
  assign a_sin = NEG_A ? -a_ext : a_ext;

  assign p_ac = a_ext * cos_i;
  assign p_bs = b_ext * sin_i;
  assign p_as = a_sin * sin_i;
  assign p_bc = b_ext * cos_i;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign sum0 = NEG_A ? ({ac_q[TW-1], ac_q} + {bs_q[TW-1], bs_q})
                      : ({ac_q[TW-1], ac_q} - {bs_q[TW-1], bs_q});
  assign sum1 = {as_q[TW-1], as_q} + {bc_q[TW-1], bc_q};

  always_comb begin
    if (sum0 > SAT_HI) begin
      sat0 = SAT_HI[CW-1:0];
    end else if (sum0 < SAT_LO) begin
      sat0 = SAT_LO[CW-1:0];
    end else begin
      sat0 = sum0[CW-1:0];
    end
    if (sum1 > SAT_HI) begin
      sat1 = SAT_HI[CW-1:0];
    end else if (sum1 < SAT_LO) begin
      sat1 = SAT_LO[CW-1:0];
    end else begin
      sat1 = sum1[CW-1:0];
    end
  end

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ac_q <= p_ac[PW-1:erot_pkg::FRAC_BITS];
      bs_q <= p_bs[PW-1:erot_pkg::FRAC_BITS];
      as_q <= p_as[PW-1:erot_pkg::FRAC_BITS];
      bc_q <= p_bc[PW-1:erot_pkg::FRAC_BITS];
      c1_q <= c_i;
    end
    if (rdy2 && v1_q) begin
      a2_q <= sat0;
      b2_q <= sat1;
      c2_q <= c1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign a_o         = a2_q;
  assign b_o         = b2_q;
  assign c_o         = c2_q;

  `EROT_ASSERT(a_accept_fills, clk_i, rst_ni, in_valid_i && in_ready_o |=> v1_q, "accepted request not captured")
  `EROT_ASSERT(a_prod_hold, clk_i, rst_ni, v1_q && !rdy2 |=> v1_q && $stable(ac_q) && $stable(bc_q), "stalled products changed")
  `EROT_ASSERT(a_out_hold, clk_i, rst_ni, v2_q && !out_ready_i |=> v2_q && $stable(a2_q) && $stable(b2_q) && $stable(c2_q), "stalled result changed")
  `EROT_ASSERT_NORST(a_reset_empty, clk_i, !rst_ni |=> !v1_q && !v2_q, "pipeline not empty after reset")

endmodule

// ----- hw/rtl/euler_xyz_vertex_rotation_unit.sv -----
// Euler XYZ vertex rotation unit: top level, APB coefficients and three axis stages.
// Depends on erot_pkg, erot_regs and erot_stage.
// Throughput: one vertex per cycle while out_ready_i is high.
// Each stage holds its data while the next one is full; two registers per axis.
// Reset: pipeline empties, coefficients return to cos 1.0 and sin 0 (identity rotation).
module euler_xyz_vertex_rotation_unit #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [erot_pkg::ADDR_W-1:0]       paddr,
  input  logic [erot_pkg::DATA_W-1:0]       pwdata,
  output logic [erot_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]     in_x_i,
  input  logic signed [COORD_WIDTH-1:0]     in_y_i,
  input  logic signed [COORD_WIDTH-1:0]     in_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COORD_WIDTH-1:0]     out_x_o,
  output logic signed [COORD_WIDTH-1:0]     out_y_o,
  output logic signed [COORD_WIDTH-1:0]     out_z_o
);

  erot_pkg::erot_coef_t         coef;
  logic                         vx, rx, vy, ry;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;

  erot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  erot_stage #(.CW(COORD_WIDTH), .NEG_A(1'b0)) u_rot_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_i         (in_y_i),
    .b_i         (in_z_i),
    .c_i         (in_x_i),
    .cos_i       (coef.cos_x),
    .sin_i       (coef.sin_x),
    .out_valid_o (vx),
    .out_ready_i (rx),
    .a_o         (y1),
    .b_o         (z1),
    .c_o         (x1)
  );

  erot_stage #(.CW(COORD_WIDTH), .NEG_A(1'b1)) u_rot_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vx),
    .in_ready_o  (rx),
    .a_i         (x1),
    .b_i         (z1),
    .c_i         (y1),
    .cos_i       (coef.cos_y),
    .sin_i       (coef.sin_y),
    .out_valid_o (vy),
    .out_ready_i (ry),
    .a_o         (x2),
    .b_o         (z2),
    .c_o         (y2)
  );

  erot_stage #(.CW(COORD_WIDTH), .NEG_A(1'b0)) u_rot_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vy),
    .in_ready_o  (ry),
    .a_i         (x2),
    .b_i         (y2),
    .c_i         (z2),
    .cos_i       (coef.cos_z),
    .sin_i       (coef.sin_z),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .a_o         (out_x_o),
    .b_o         (out_y_o),
    .c_o         (out_z_o)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for euler_xyz_vertex_rotation_unit: rotates random and corner-case
// vertices under several coefficient sets and checks every result against an in-bench model.
// Depends on erot_pkg and the RTL of the unit; nothing else.
module testbench;

  localparam int COORD_W = 20;
  localparam int LATENCY = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 60;
  localparam int HOLD_AFTER = 150;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 92;
  localparam logic [erot_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [erot_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [erot_pkg::COEF_W-1:0] coef_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  class vertex_rotation_checker;
    coef_t   coef [6];
    vertex_t rotated_vertices [$];
    int      errors;

    function new();
      coef[erot_pkg::REG_COS_X] = erot_pkg::COEF_ONE;
      coef[erot_pkg::REG_SIN_X] = erot_pkg::COEF_ZERO;
      coef[erot_pkg::REG_COS_Y] = erot_pkg::COEF_ONE;
      coef[erot_pkg::REG_SIN_Y] = erot_pkg::COEF_ZERO;
      coef[erot_pkg::REG_COS_Z] = erot_pkg::COEF_ONE;
      coef[erot_pkg::REG_SIN_Z] = erot_pkg::COEF_ZERO;
      errors = 0;
    endfunction

    function void set_coef(logic [erot_pkg::IDX_W-1:0] idx, coef_t val);
      if (idx <= erot_pkg::REG_SIN_Z) begin
        coef[idx] = val;
      end
    endfunction

    function longint clamp(longint v);
      if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return v;
    endfunction

    function longint scale(longint a, coef_t c);
      longint p;
      p = a * longint'(c);
      return p >>> erot_pkg::FRAC_BITS;
    endfunction

    function vertex_t rotate_xyz(vertex_t v);
      longint x, y, z, nx, ny, nz;
      vertex_t r;
      x = v.x;
      y = v.y;
      z = v.z;
      ny = clamp(scale(y, coef[erot_pkg::REG_COS_X]) - scale(z, coef[erot_pkg::REG_SIN_X]));
      nz = clamp(scale(y, coef[erot_pkg::REG_SIN_X]) + scale(z, coef[erot_pkg::REG_COS_X]));
      y = ny;
      z = nz;
      nx = clamp(scale(x, coef[erot_pkg::REG_COS_Y]) + scale(z, coef[erot_pkg::REG_SIN_Y]));
      nz = clamp(scale(-x, coef[erot_pkg::REG_SIN_Y]) + scale(z, coef[erot_pkg::REG_COS_Y]));
      x = nx;
      z = nz;
      nx = clamp(scale(x, coef[erot_pkg::REG_COS_Z]) - scale(y, coef[erot_pkg::REG_SIN_Z]));
      ny = clamp(scale(x, coef[erot_pkg::REG_SIN_Z]) + scale(y, coef[erot_pkg::REG_COS_Z]));
      r.x = coord_t'(nx);
      r.y = coord_t'(ny);
      r.z = coord_t'(z);
      return r;
    endfunction

    function void note_request(coord_t x, coord_t y, coord_t z);
      vertex_t v;
      v.x = x;
      v.y = y;
      v.z = z;
      rotated_vertices.push_back(rotate_xyz(v));
    endfunction

    function void compare_field(string name, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(coord_t x, coord_t y, coord_t z);
      vertex_t e;
      if (rotated_vertices.size() == 0) begin
        $error("result (%0d, %0d, %0d) arrived with none outstanding", x, y, z);
        errors++;
        return;
      end
      e = rotated_vertices.pop_front();
      compare_field("out_x", e.x, x);
      compare_field("out_y", e.y, y);
      compare_field("out_z", e.z, z);
    endfunction

    function int pending();
      return rotated_vertices.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [erot_pkg::ADDR_W-1:0] paddr;
  logic [erot_pkg::DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  coord_t in_x_i, in_y_i, in_z_i, out_x_o, out_y_o, out_z_o;

  vertex_rotation_checker chk = new();
  bit quiet_tail = 1'b0;
  int results_seen = 0;
  int stall_cycles = 0;

  always #6 clk_i = ~clk_i;

  euler_xyz_vertex_rotation_unit #(
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .in_z_i     (in_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o)
  );

  always @(posedge clk_i) begin
    bit active;
    active = 1'b0;
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) begin
        chk.note_request(in_x_i, in_y_i, in_z_i);
        active = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        chk.check_result(out_x_o, out_y_o, out_z_o);
        results_seen++;
        active = 1'b1;
      end
      if (psel && penable) begin
        active = 1'b1;
      end
    end
    stall_cycles = active ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7)) inside
      0: return COORD_MAX;
      1: return COORD_MIN;
      [2:3]: return coord_t'($urandom_range(0, 4096)) - coord_t'(2048);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 9)) inside
      0: return erot_pkg::COEF_ONE;
      1: return -erot_pkg::COEF_ONE;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return erot_pkg::COEF_ZERO;
      [5:6]: return coef_t'($urandom());
      default: return coef_t'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i <= x;
    in_y_i <= y;
    in_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_coef(input logic [erot_pkg::IDX_W-1:0] idx, input coef_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chk.set_coef(idx, val);
  endtask

  task automatic program_angles(input coef_t cx, input coef_t sx, input coef_t cy,
                                input coef_t sy, input coef_t cz, input coef_t sz);
    write_coef(erot_pkg::REG_COS_X, cx);
    write_coef(erot_pkg::REG_SIN_X, sx);
    write_coef(erot_pkg::REG_COS_Y, cy);
    write_coef(erot_pkg::REG_SIN_Y, sy);
    write_coef(erot_pkg::REG_COS_Z, cz);
    write_coef(erot_pkg::REG_SIN_Z, sz);
    write_coef($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand_coef());
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    in_x_i <= '0;
    in_y_i <= '0;
    in_z_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0));
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_vertex(coord_t'(1), coord_t'(-1), COORD_MAX);
    send_vertex(COORD_MIN, COORD_MAX, coord_t'(0));
    settle();

    program_angles(erot_pkg::COEF_ZERO, erot_pkg::COEF_ONE, erot_pkg::COEF_ZERO,
                   erot_pkg::COEF_ONE, erot_pkg::COEF_ZERO, erot_pkg::COEF_ONE);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(1));
    send_vertex(COORD_MIN, COORD_MAX, coord_t'(-1));
    send_vertex(coord_t'(-1), coord_t'(1), COORD_MIN);
    send_vertex(coord_t'(16), coord_t'(-16), coord_t'(32));
    settle();

    program_angles(-erot_pkg::COEF_ONE, -erot_pkg::COEF_ONE, -erot_pkg::COEF_ONE,
                   -erot_pkg::COEF_ONE, -erot_pkg::COEF_ONE, -erot_pkg::COEF_ONE);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(0));
    send_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    settle();

    program_angles(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
    send_vertex(coord_t'(1), coord_t'(1), coord_t'(1));
    send_vertex(COORD_MIN, coord_t'(-1), COORD_MAX);
    send_vertex(coord_t'(-3), coord_t'(5), coord_t'(-7));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_angles(rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_coef());
      if (p == RANDOM_PHASES - 1) begin
        quiet_tail = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord());
      end
      settle();
    end

    if (chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
